// File: hw/rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg: shared definitions for the tick timestamp capture block
// Command codes, register indexes, widths and the slot store control bundle.
// ----------------------------------------------------------------------------
package ttc_pkg;

  // number of timestamp slots and the widths that follow from it
  localparam int unsigned SLOT_COUNT  = 16;
  localparam int unsigned SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned SLOT_PTR_W  = $clog2(SLOT_COUNT + 1);

  // fixed field widths
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned RES_W       = 16;
  localparam int unsigned SLOT_FLD_W  = 8;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_CAPTURE = 3'd3,
    CMD_MEASURE = 3'd4,
    CMD_READ    = 3'd5
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_RES  = 1'b0,
    CFG_TIME_UNIT = 1'b1
  } cfg_reg_e;

  // control from the command logic to the slot store
  typedef struct packed {
    logic                  clear;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_addr;
    logic [COUNT_W-1:0]    wr_data;
  } slot_ctrl_t;

endpackage

// File: hw/rtl/ttc_slot_store.sv
// ----------------------------------------------------------------------------
// ttc_slot_store: timestamp slot memory
// One write port, two registered read ports, per-slot valid bits for the
// bulk clear, and forwarding of a write that lands on the edge of a read.
// ----------------------------------------------------------------------------
module ttc_slot_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ttc_pkg::slot_ctrl_t            ctrl_i,
  input  logic [ttc_pkg::SLOT_IDX_W-1:0] rd_addr_a_i,
  input  logic [ttc_pkg::SLOT_IDX_W-1:0] rd_addr_b_i,
  output logic [ttc_pkg::COUNT_W-1:0]    rd_data_a_o,
  output logic [ttc_pkg::COUNT_W-1:0]    rd_data_b_o
);
  import ttc_pkg::*;

  logic [COUNT_W-1:0]    mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [COUNT_W-1:0]    mem_a_q, mem_b_q, fwd_data_q;
  logic                  zero_a_q, zero_b_q, fwd_a_q, fwd_b_q;
  logic                  hit_a, hit_b;

  // write hitting a read address on the same edge
  assign hit_a = ctrl_i.wr_en && (ctrl_i.wr_addr == rd_addr_a_i);
  assign hit_b = ctrl_i.wr_en && (ctrl_i.wr_addr == rd_addr_b_i);

  // valid bits: clear drops all, a write marks its slot
  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = '0;
    end else if (ctrl_i.wr_en) begin
      valid_d[ctrl_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // memory array with registered reads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    mem_a_q <= mem[rd_addr_a_i];
    mem_b_q <= mem[rd_addr_b_i];
  end

  // read side selects, sampled with the read
  always_ff @(posedge clk_i) begin
    zero_a_q   <= ctrl_i.clear || (!valid_q[rd_addr_a_i] && !hit_a);
    zero_b_q   <= ctrl_i.clear || (!valid_q[rd_addr_b_i] && !hit_b);
    fwd_a_q    <= !ctrl_i.clear && hit_a;
    fwd_b_q    <= !ctrl_i.clear && hit_b;
    fwd_data_q <= ctrl_i.wr_data;
  end

  // cleared slots read as zero, forwarded writes win over the array
  assign rd_data_a_o = zero_a_q ? '0 : (fwd_a_q ? fwd_data_q : mem_a_q);
  assign rd_data_b_o = zero_b_q ? '0 : (fwd_b_q ? fwd_data_q : mem_b_q);

endmodule

// File: hw/rtl/tick_timestamp_capture.sv
// ----------------------------------------------------------------------------
// tick_timestamp_capture: execution-time measurement unit
// Tick counter with timestamp slots, slot differences scaled to a time.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start_i with command_i, first_slot_i and last_slot_i;
//   a command transfer happens on every edge with start_i high and busy_o
//   low. busy_o stays low, so one command can be issued every cycle.
//   Each command gives one result on ok_o, captured_index_o,
//   measured_time_o and result_unit_o, marked by result_valid_o for a single
//   cycle; the receiver cannot stall and must take it in that cycle.
//   The command is registered together with the slot reads, then the
//   command logic and the 16x32 multiply settle into the result register.
//   Throughput is one command per cycle; slot and counter updates of one
//   command are seen by the next one.
//   Configuration (tick resolution, time unit) is written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i while no command is in flight; a start copies
//   it into the working copy used by measure.
//   Reset clears the counter, slot pointer, running flag, slot valid bits,
//   configuration and any result in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tick_timestamp_capture (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [ttc_pkg::CMD_W-1:0]      command_i,
  input  logic [ttc_pkg::SLOT_FLD_W-1:0] first_slot_i,
  input  logic [ttc_pkg::SLOT_FLD_W-1:0] last_slot_i,
  // result channel
  output logic                           result_valid_o,
  output logic                           ok_o,
  output logic [ttc_pkg::SLOT_FLD_W-1:0] captured_index_o,
  output logic [ttc_pkg::COUNT_W-1:0]    measured_time_o,
  output logic                           result_unit_o,
  // configuration port
  input  logic                           cfg_we_i,
  input  logic [ttc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ttc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ttc_pkg::*;

  logic                  accept;

  // configuration registers
  logic [RES_W-1:0]      tick_res_q;
  logic                  time_unit_q;

  // architectural state
  logic [COUNT_W-1:0]    tick_count_q, tick_count_d;
  logic [SLOT_PTR_W-1:0] next_slot_q, next_slot_d;
  logic                  running_q, running_d;
  logic [RES_W-1:0]      held_res_q, held_res_d;
  logic                  held_unit_q, held_unit_d;

  // command register
  logic                  s1_valid_q;
  cmd_e                  s1_cmd_q;
  logic [SLOT_FLD_W-1:0] s1_first_q, s1_last_q;

  // slot store
  slot_ctrl_t            slot_ctrl;
  logic [COUNT_W-1:0]    slot_a, slot_b;

  // command logic results
  logic                  ok_d, unit_d;
  logic [SLOT_FLD_W-1:0] cap_d;
  logic [COUNT_W-1:0]    meas_d;
  logic                  use_mult;
  logic [COUNT_W-1:0]    mult_op;
  logic [COUNT_W-1:0]    product;
  logic                  in_range, diff_ok, both_zero;

  // result register
  logic                  res_valid_q;
  logic                  res_ok_q, res_unit_q;
  logic [SLOT_FLD_W-1:0] res_cap_q;
  logic [COUNT_W-1:0]    res_meas_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // configuration writes; both values of the one-bit index select a register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_res_q  <= '0;
      time_unit_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TICK_RES:  tick_res_q  <= cfg_wdata_i[RES_W-1:0];
        CFG_TIME_UNIT: time_unit_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= cmd_e'(command_i);
      s1_first_q <= first_slot_i;
      s1_last_q  <= last_slot_i;
    end
  end

  // slot reads are taken with the command transfer
  ttc_slot_store u_slot_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (slot_ctrl),
    .rd_addr_a_i (first_slot_i[SLOT_IDX_W-1:0]),
    .rd_addr_b_i (last_slot_i[SLOT_IDX_W-1:0]),
    .rd_data_a_o (slot_a),
    .rd_data_b_o (slot_b)
  );

  // measure conditions
  assign in_range  = (s1_first_q < SLOT_FLD_W'(SLOT_COUNT)) &&
                     (s1_last_q < SLOT_FLD_W'(SLOT_COUNT));
  assign diff_ok   = slot_b > slot_a;
  assign both_zero = (s1_first_q == '0) && (s1_last_q == '0);

  // single multiplier: held resolution times difference or count, low word only
  assign mult_op = diff_ok ? (slot_b - slot_a) : tick_count_q;
  assign product = COUNT_W'(held_res_q) * mult_op;

  // command decode and state update
  always_comb begin
    tick_count_d      = tick_count_q;
    next_slot_d       = next_slot_q;
    running_d         = running_q;
    held_res_d        = held_res_q;
    held_unit_d       = held_unit_q;
    slot_ctrl.clear   = 1'b0;
    slot_ctrl.wr_en   = 1'b0;
    slot_ctrl.wr_addr = next_slot_q[SLOT_IDX_W-1:0];
    slot_ctrl.wr_data = tick_count_q;
    ok_d              = 1'b0;
    cap_d             = '0;
    meas_d            = '0;
    unit_d            = 1'b0;
    use_mult          = 1'b0;
    if (s1_valid_q) begin
      unique case (s1_cmd_q)
        CMD_TICK: begin
          if (running_q) begin
            tick_count_d = tick_count_q + COUNT_W'(1);
          end
          ok_d = 1'b1;
        end
        CMD_START: begin
          if (tick_res_q != '0) begin
            slot_ctrl.clear = 1'b1;
            next_slot_d     = '0;
            tick_count_d    = '0;
            held_res_d      = tick_res_q;
            held_unit_d     = time_unit_q;
            running_d       = 1'b1;
            ok_d            = 1'b1;
          end
        end
        CMD_STOP: begin
          running_d = 1'b0;
          ok_d      = 1'b1;
        end
        CMD_CAPTURE: begin
          if (next_slot_q < SLOT_PTR_W'(SLOT_COUNT)) begin
            slot_ctrl.wr_en = 1'b1;
            cap_d           = SLOT_FLD_W'(next_slot_q);
            next_slot_d     = next_slot_q + SLOT_PTR_W'(1);
            ok_d            = 1'b1;
          end
        end
        CMD_MEASURE: begin
          if (in_range && (diff_ok || both_zero)) begin
            use_mult = 1'b1;
            unit_d   = held_unit_q;
            ok_d     = 1'b1;
          end
        end
        CMD_READ: begin
          meas_d = tick_count_q;
          ok_d   = 1'b1;
        end
        default: ;
      endcase
    end
    if (use_mult) begin
      meas_d = product;
    end
  end

  // architectural state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      next_slot_q  <= '0;
      running_q    <= 1'b0;
      held_res_q   <= '0;
      held_unit_q  <= 1'b0;
    end else begin
      tick_count_q <= tick_count_d;
      next_slot_q  <= next_slot_d;
      running_q    <= running_d;
      held_res_q   <= held_res_d;
      held_unit_q  <= held_unit_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_ok_q   <= ok_d;
    res_cap_q  <= cap_d;
    res_meas_q <= meas_d;
    res_unit_q <= unit_d;
  end

  assign result_valid_o   = res_valid_q;
  assign ok_o             = res_ok_q;
  assign captured_index_o = res_cap_q;
  assign measured_time_o  = res_meas_q;
  assign result_unit_o    = res_unit_q;

`ifndef SYNTH
  // every command transfer yields its result through the command and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 result_valid_o)
    else $error("result missing two cycles after command transfer");

  // a failed command carries an all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !ok_o) |->
      (captured_index_o == '0) && (measured_time_o == '0) && !result_unit_o)
    else $error("failed command with nonzero payload");

  // slot pointer never passes the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= SLOT_PTR_W'(SLOT_COUNT))
    else $error("slot pointer beyond slot count");

  // a successful start leaves the count cleared and running set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_cmd_q == CMD_START) && (tick_res_q != '0)) |=>
      (tick_count_q == '0) && running_q && (next_slot_q == '0))
    else $error("start did not reset the counter state");
`endif

endmodule

// File: verif/tick_timestamp_capture_tb.sv
// ----------------------------------------------------------------------------
// tick_timestamp_capture_tb: self-checking bench for the timestamp capture unit
// A directed table, then random command bursts over several configurations
// and sender idle rates. Results are checked against a model or pinned rows.
// ----------------------------------------------------------------------------
module tick_timestamp_capture_tb;
  import ttc_pkg::*;

  // result of one command, as seen on the result ports
  typedef struct packed {
    logic                  ok;
    logic [SLOT_FLD_W-1:0] cap;
    logic [COUNT_W-1:0]    meas;
    logic                  unit;
  } ttc_result_t;

  // a result typed into the table, or left to the model
  typedef struct packed {
    logic        fixed;
    ttc_result_t val;
  } pinned_t;

  // one row of the directed table: a register setting or a command
  typedef struct packed {
    logic                  is_cfg;
    logic [RES_W-1:0]      res;
    logic                  unit;
    logic [CMD_W-1:0]      cmd;
    logic [SLOT_FLD_W-1:0] fs;
    logic [SLOT_FLD_W-1:0] ls;
    logic                  pinned;
    ttc_result_t           exp_res;
  } dir_row_t;

  // command codes the block does not know
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam ttc_result_t R_FAIL = '{1'b0, 8'd0, 32'd0, 1'b0};
  localparam ttc_result_t R_OK   = '{1'b1, 8'd0, 32'd0, 1'b0};

  localparam int unsigned STALL_LIMIT  = 500;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned DIR_ROWS     = 26;

  // ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [CMD_W-1:0]      command_i;
  logic [SLOT_FLD_W-1:0] first_slot_i;
  logic [SLOT_FLD_W-1:0] last_slot_i;
  logic                  result_valid_o;
  logic                  ok_o;
  logic [SLOT_FLD_W-1:0] captured_index_o;
  logic [COUNT_W-1:0]    measured_time_o;
  logic                  result_unit_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  tick_timestamp_capture dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .first_slot_i    (first_slot_i),
    .last_slot_i     (last_slot_i),
    .result_valid_o  (result_valid_o),
    .ok_o            (ok_o),
    .captured_index_o(captured_index_o),
    .measured_time_o (measured_time_o),
    .result_unit_o   (result_unit_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // timer model state
  logic [RES_W-1:0]      reg_res;
  logic                  reg_unit;
  logic [COUNT_W-1:0]    m_count;
  logic [COUNT_W-1:0]    m_slots [SLOT_COUNT];
  logic [SLOT_PTR_W-1:0] m_next;
  logic                  m_running;
  logic [RES_W-1:0]      m_res;
  logic                  m_unit;

  ttc_result_t due_results [$];
  pinned_t     pinned_q [$];
  int unsigned err_count;
  int unsigned stall_cycles;
  int unsigned idle_pct;

  // model of one command: updates the timer state, returns its result
  function automatic ttc_result_t timer_step(logic [CMD_W-1:0] cmd,
                                             logic [SLOT_FLD_W-1:0] fs,
                                             logic [SLOT_FLD_W-1:0] ls);
    ttc_result_t r;
    logic [COUNT_W-1:0] a;
    logic [COUNT_W-1:0] b;
    r = R_FAIL;
    case (cmd)
      CMD_TICK: begin
        if (m_running) m_count = m_count + 32'd1;
        r.ok = 1'b1;
      end
      CMD_START: begin
        if (reg_res != '0) begin
          for (int i = 0; i < SLOT_COUNT; i++) m_slots[i] = '0;
          m_next    = '0;
          m_count   = '0;
          m_res     = reg_res;
          m_unit    = reg_unit;
          m_running = 1'b1;
          r.ok      = 1'b1;
        end
      end
      CMD_STOP: begin
        m_running = 1'b0;
        r.ok      = 1'b1;
      end
      CMD_CAPTURE: begin
        if (m_next < SLOT_COUNT) begin
          m_slots[m_next[SLOT_IDX_W-1:0]] = m_count;
          r.cap  = SLOT_FLD_W'(m_next);
          m_next = m_next + 1'b1;
          r.ok   = 1'b1;
        end
      end
      CMD_MEASURE: begin
        if (fs < SLOT_COUNT && ls < SLOT_COUNT) begin
          a = m_slots[fs[SLOT_IDX_W-1:0]];
          b = m_slots[ls[SLOT_IDX_W-1:0]];
          // slot difference first, whole count when both indices are zero
          if (b > a) begin
            r.meas = COUNT_W'(m_res * (b - a));
            r.unit = m_unit;
            r.ok   = 1'b1;
          end else if (fs == '0 && ls == '0) begin
            r.meas = COUNT_W'(m_res * m_count);
            r.unit = m_unit;
            r.ok   = 1'b1;
          end
        end
      end
      CMD_READ: begin
        r.meas = m_count;
        r.ok   = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // one line per mismatch
  task automatic report_mismatch(string what, logic [COUNT_W-1:0] want,
                                 logic [COUNT_W-1:0] got);
    $display("mismatch %s: expected %0h got %0h", what, want, got);
    err_count++;
  endtask

  // watch both channels: model on command transfer, check on result
  always @(posedge clk_i) begin
    ttc_result_t want;
    ttc_result_t pred;
    pinned_t     pin;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", '0, COUNT_W'(1));
        end else begin
          want = due_results.pop_front();
          if (ok_o !== want.ok)
            report_mismatch("ok", COUNT_W'(want.ok), COUNT_W'(ok_o));
          if (captured_index_o !== want.cap)
            report_mismatch("captured_index", COUNT_W'(want.cap),
                            COUNT_W'(captured_index_o));
          if (measured_time_o !== want.meas)
            report_mismatch("measured_time", want.meas, measured_time_o);
          if (result_unit_o !== want.unit)
            report_mismatch("result_unit", COUNT_W'(want.unit),
                            COUNT_W'(result_unit_o));
        end
      end
      if (start_i && !busy_o) begin
        pred = timer_step(command_i, first_slot_i, last_slot_i);
        pin  = pinned_q.pop_front();
        due_results.push_back(pin.fixed ? pin.val : pred);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TICK_RES:  reg_res  = cfg_wdata_i[RES_W-1:0];
          CFG_TIME_UNIT: reg_unit = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    // watchdog on cycles with no transfer
    if ((start_i && !busy_o) || result_valid_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // issue one command, with random sender gaps ahead of it
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_FLD_W-1:0] fs,
                          logic [SLOT_FLD_W-1:0] ls, logic fixed = 1'b0,
                          ttc_result_t val = R_FAIL);
    pinned_t pin;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i      <= 1'b0;
      command_i    <= CMD_W'($urandom);
      first_slot_i <= SLOT_FLD_W'($urandom);
      last_slot_i  <= SLOT_FLD_W'($urandom);
      @(posedge clk_i);
    end
    pin.fixed = fixed;
    pin.val   = val;
    pinned_q.push_back(pin);
    start_i      <= 1'b1;
    command_i    <= cmd;
    first_slot_i <= fs;
    last_slot_i  <= ls;
    do @(posedge clk_i); while (busy_o);
  endtask

  // let every result come back, then write both registers
  task automatic write_regs(logic [RES_W-1:0] res, logic unit);
    start_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TICK_RES;
    cfg_wdata_i <= res;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TIME_UNIT;
    cfg_wdata_i <= {15'($urandom), unit};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // measure indices: mostly in range, some both zero, some anywhere
  task automatic send_measure();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70)
      send_cmd(CMD_MEASURE, SLOT_FLD_W'($urandom_range(0, SLOT_COUNT - 1)),
               SLOT_FLD_W'($urandom_range(0, SLOT_COUNT - 1)));
    else if (k < 85)
      send_cmd(CMD_MEASURE, '0, '0);
    else
      send_cmd(CMD_MEASURE, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
  endtask

  dir_row_t    dir_tab [DIR_ROWS];
  int unsigned pct_tab [4] = '{0, 67, 0, 7};

  initial begin
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    logic [RES_W-1:0] res;

    err_count    = 0;
    stall_cycles = 0;
    idle_pct     = 0;
    reg_res      = '0;
    reg_unit     = 1'b0;
    m_count      = '0;
    m_next       = '0;
    m_running    = 1'b0;
    m_res        = '0;
    m_unit       = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) m_slots[i] = '0;

    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    command_i    <= CMD_TICK;
    first_slot_i <= '0;
    last_slot_i  <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_TICK_RES;
    cfg_wdata_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: reset values, zero resolution, unknown codes,
    // slot differences, reversed and out-of-range indices, stop behavior
    dir_tab = '{
      '{1'b0, 16'h0,    1'b0, CMD_MEASURE,  8'd0,   8'd0,   1'b1, R_OK},
      '{1'b0, 16'h0,    1'b0, CMD_START,    8'd0,   8'd0,   1'b1, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_READ,     8'd0,   8'd0,   1'b1, R_OK},
      '{1'b0, 16'h0,    1'b0, CMD_TICK,     8'd255, 8'd255, 1'b1, R_OK},
      '{1'b0, 16'h0,    1'b0, CMD_CAPTURE,  8'd0,   8'd0,   1'b1, R_OK},
      '{1'b0, 16'h0,    1'b0, CMD_UNUSED_6, 8'd255, 8'd255, 1'b1, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_UNUSED_7, 8'd0,   8'd0,   1'b1, R_FAIL},
      '{1'b1, 16'hFFFF, 1'b1, CMD_TICK,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_START,    8'd0,   8'd0,   1'b1, R_OK},
      '{1'b0, 16'h0,    1'b0, CMD_TICK,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_TICK,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_TICK,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_CAPTURE,  8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_TICK,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_TICK,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_CAPTURE,  8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_MEASURE,  8'd0,   8'd1,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_MEASURE,  8'd1,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_MEASURE,  8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_MEASURE,  8'd16,  8'd0,   1'b1, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_MEASURE,  8'd0,   8'd255, 1'b1, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_STOP,     8'd0,   8'd0,   1'b1, R_OK},
      '{1'b0, 16'h0,    1'b0, CMD_TICK,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_READ,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b1, 16'h1,    1'b0, CMD_TICK,     8'd0,   8'd0,   1'b0, R_FAIL},
      '{1'b0, 16'h0,    1'b0, CMD_START,    8'd0,   8'd0,   1'b1, R_OK}
    };
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_cfg)
        write_regs(dir_tab[i].res, dir_tab[i].unit);
      else
        send_cmd(dir_tab[i].cmd, dir_tab[i].fs, dir_tab[i].ls,
                 dir_tab[i].pinned, dir_tab[i].exp_res);
    end

    // random bursts, one register setting and idle rate per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       res = 16'h1;
        1:       res = 16'hFFFF;
        2:       res = 16'h0;
        default: res = RES_W'($urandom);
      endcase
      idle_pct = 0;
      write_regs(res, ph[0]);
      idle_pct = pct_tab[ph % 4];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          // fill every slot and run past the end
          send_cmd(CMD_START, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
          sent++;
          for (int j = 0; j < SLOT_COUNT + 2; j++) begin
            n = $urandom_range(0, 3);
            for (int t = 0; t < n; t++) begin
              send_cmd(CMD_TICK, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
              sent++;
            end
            send_cmd(CMD_CAPTURE, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
            sent++;
          end
          repeat (4) begin
            send_measure();
            sent++;
          end
        end else if (kind < 85) begin
          // mostly a start, then a mix weighted toward ticks
          if ($urandom_range(0, 9) != 0) begin
            send_cmd(CMD_START, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
            sent++;
          end
          n = $urandom_range(10, 50);
          for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, 99);
            if (k < 50)
              send_cmd(CMD_TICK, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
            else if (k < 70)
              send_cmd(CMD_CAPTURE, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
            else if (k < 87)
              send_measure();
            else if (k < 94)
              send_cmd(CMD_READ, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
            else if (k < 98)
              send_cmd(CMD_STOP, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
            else
              send_cmd(CMD_START, SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
            sent++;
          end
        end else begin
          // noise: any code, any indices
          n = $urandom_range(3, 10);
          for (int j = 0; j < n; j++) begin
            send_cmd(CMD_W'($urandom), SLOT_FLD_W'($urandom), SLOT_FLD_W'($urandom));
            sent++;
          end
        end
      end
    end

    // drain and finish
    start_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch("results left over", '0, COUNT_W'(due_results.size()));
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
